>>> rtl/rph_pkg.sv
// Shared constants and codes for the ray/parallelogram hit test.
package rph_pkg;

  // Default coordinate format: signed Q10.10 in 20 bits
  localparam int COORD_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 10;

  // Fixed field widths
  localparam int DIST_BITS     = 19;
  localparam int MIN_DIST_BITS = 10;
  localparam int UV_FRAC       = 16;
  localparam int UV_BITS       = UV_FRAC + 1;
  localparam int CFG_IDX_BITS  = 2;

  // Front end 7, distance divider, 5 middle stages, u/v divider, output register
  localparam int PIPE_LATENCY = 13 + DIST_BITS + UV_FRAC;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CORNER_ORIGIN = 2'd0,
    CFG_CORNER_FIRST  = 2'd1,
    CFG_CORNER_SECOND = 2'd2,
    CFG_MIN_DIST      = 2'd3
  } cfg_idx_t;

endpackage

>>> rtl/ray_parallelogram_hit.sv
// Pipelined ray versus parallelogram hit test (Cramer's rule, fixed point).
// Each accepted start emerges as the out_valid strobe at the end of the valid shift line.
// Throughput: one ray word per cycle; busy is low whenever reset is released.
// The depth is set by the 19-step restoring divider for the distance and the
// 16-step restoring dividers for u and v, one quotient bit per stage.
// Reset (rst_n low, synchronous) clears the pipeline valids and loads the corner
// and minimum distance registers with their defaults; the receiver cannot stall.
module ray_parallelogram_hit #(
  parameter int COORD_BITS = rph_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rph_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        in_origin_x,
  input  logic signed [COORD_BITS-1:0]        in_origin_y,
  input  logic signed [COORD_BITS-1:0]        in_origin_z,
  input  logic signed [COORD_BITS-1:0]        in_dir_x,
  input  logic signed [COORD_BITS-1:0]        in_dir_y,
  input  logic signed [COORD_BITS-1:0]        in_dir_z,
  input  logic [rph_pkg::DIST_BITS-1:0]       in_nearest_so_far,
  output logic                                out_valid,
  output logic                                out_is_hit,
  output logic [rph_pkg::DIST_BITS-1:0]       out_hit_distance,
  output logic signed [COORD_BITS-1:0]        out_point_x,
  output logic signed [COORD_BITS-1:0]        out_point_y,
  output logic signed [COORD_BITS-1:0]        out_point_z,
  output logic [rph_pkg::UV_BITS-1:0]         out_surf_u,
  output logic [rph_pkg::UV_BITS-1:0]         out_surf_v,
  input  logic                                cfg_we,
  input  logic [rph_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [3*COORD_BITS-1:0]             cfg_data
);
  import rph_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DB   = DIST_BITS;
  localparam int UF   = UV_FRAC;
  localparam int LAT  = PIPE_LATENCY;
  localparam int DW   = C + 1;          // coordinate difference
  localparam int MW   = 2 * DW + 1;     // 2x2 minor
  localparam int LO   = MW / 2;         // low split of a minor
  localparam int TW   = DW + MW;        // one determinant term
  localparam int DETW = TW + 2;         // sum of three terms
  localparam int WW   = DETW + DB + F;  // distance divider width
  localparam int PRW  = DB + 1 + C;     // t * direction
  localparam int SW   = PRW + 1;        // origin plus offset
  localparam int PW   = 2 * DW;         // edge product
  localparam int DOTW = PW + 2;         // dot / squared length
  localparam int UW   = DOTW + UF;      // u/v divider width

  localparam logic signed [SW-1:0] PT_MAX = SW'((2 ** (C - 1)) - 1);
  localparam logic signed [SW-1:0] PT_MIN = SW'(-(2 ** (C - 1)));
  localparam logic [UV_BITS-1:0]   UV_ONE = UV_BITS'(2 ** UF);

  // Determinant terms: multiplier operand (a,b,c,d) and minor (m,n,p,q,s,r)
  localparam int TX [12] = '{0, 1, 2, 3, 1, 2, 0, 3, 2, 0, 1, 3};
  localparam int TY [12] = '{0, 3, 4, 0, 1, 2, 1, 3, 5, 2, 5, 4};

  typedef struct packed {
    logic [2:0][C-1:0] o;
    logic [2:0][C-1:0] dv;
    logic [DB-1:0]     nearest;
  } ray_t;

  typedef struct packed {
    ray_t          ray;
    logic          miss;
    logic          clamp;
    logic [DETW-1:0] den;
    logic [WW-1:0] rem;
    logic [DB-1:0] q;
  } tdiv_t;

  typedef struct packed {
    logic              hit;
    logic [DB-1:0]     tdist;
    logic [2:0][C-1:0] pt;
  } res_t;

  typedef struct packed {
    res_t            res;
    logic            zu;
    logic            su;
    logic            zv;
    logic            sv;
    logic [DOTW-1:0] lu;
    logic [DOTW-1:0] lv;
    logic [UW-1:0]   ru;
    logic [UW-1:0]   rv;
    logic [UF-1:0]   qu;
    logic [UF-1:0]   qv;
  } udiv_t;

  function automatic logic signed [MW-1:0] minor2(input logic signed [DW-1:0] p, q, r, s);
    minor2 = MW'(p) * MW'(q) - MW'(r) * MW'(s);
  endfunction

  // Configuration registers
  logic [3*C-1:0]         corner_org_r, corner_e1_r, corner_e2_r;
  logic [MIN_DIST_BITS-1:0] min_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_org_r <= '0;
      corner_e1_r  <= (3*C)'(2 ** F);
      corner_e2_r  <= (3*C)'(2 ** F) << C;
      min_dist_r   <= MIN_DIST_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CORNER_ORIGIN: corner_org_r <= cfg_data;
        CFG_CORNER_FIRST:  corner_e1_r  <= cfg_data;
        CFG_CORNER_SECOND: corner_e2_r  <= cfg_data;
        CFG_MIN_DIST:      min_dist_r   <= cfg_data[MIN_DIST_BITS-1:0];
      endcase
    end
  end

  logic signed [C-1:0] p0 [3];
  logic signed [C-1:0] p1 [3];
  logic signed [C-1:0] p2 [3];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      p0[x] = $signed(corner_org_r[x*C +: C]);
      p1[x] = $signed(corner_e1_r[x*C +: C]);
      p2[x] = $signed(corner_e2_r[x*C +: C]);
    end
  end

  // Handshake and valid shift line (no stalls, so valids just advance)
  logic           accept;
  logic [LAT-1:0] vld_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // Stage A: edge and origin differences
  ray_t                a_ray_r;
  logic signed [DW-1:0] a_ea_r [3];
  logic signed [DW-1:0] a_eb_r [3];
  logic signed [DW-1:0] a_eo_r [3];
  logic signed [C-1:0]  in_o [3];
  logic signed [C-1:0]  in_d [3];

  assign in_o[0] = in_origin_x;
  assign in_o[1] = in_origin_y;
  assign in_o[2] = in_origin_z;
  assign in_d[0] = in_dir_x;
  assign in_d[1] = in_dir_y;
  assign in_d[2] = in_dir_z;

  always_ff @(posedge clk) begin
    for (int x = 0; x < 3; x++) begin
      a_ea_r[x]     <= DW'(p0[x]) - DW'(p1[x]);
      a_eb_r[x]     <= DW'(p0[x]) - DW'(p2[x]);
      a_eo_r[x]     <= DW'(p0[x]) - DW'(in_o[x]);
      a_ray_r.o[x]  <= in_o[x];
      a_ray_r.dv[x] <= in_d[x];
    end
    a_ray_r.nearest <= in_nearest_so_far;
  end

  // Stage B: the six 2x2 minors, plus the first row operands
  ray_t                 b_ray_r;
  logic signed [MW-1:0] b_m_r [6];
  logic signed [DW-1:0] b_x_r [4];
  logic signed [DW-1:0] dvw [3];

  always_comb begin
    for (int x = 0; x < 3; x++) dvw[x] = DW'($signed(a_ray_r.dv[x]));
  end

  always_ff @(posedge clk) begin
    b_m_r[0] <= minor2(a_eb_r[1], dvw[2], dvw[1], a_eb_r[2]);       // m
    b_m_r[1] <= minor2(a_eo_r[1], dvw[2], dvw[1], a_eo_r[2]);       // n
    b_m_r[2] <= minor2(a_eb_r[1], a_eo_r[2], a_eo_r[1], a_eb_r[2]); // p
    b_m_r[3] <= minor2(dvw[1], a_ea_r[2], a_ea_r[1], dvw[2]);       // q
    b_m_r[4] <= minor2(a_ea_r[1], a_eb_r[2], a_eb_r[1], a_ea_r[2]); // s
    b_m_r[5] <= minor2(a_ea_r[1], a_eo_r[2], a_eo_r[1], a_ea_r[2]); // r
    b_x_r[0] <= a_ea_r[0];
    b_x_r[1] <= a_eb_r[0];
    b_x_r[2] <= dvw[0];
    b_x_r[3] <= a_eo_r[0];
    b_ray_r  <= a_ray_r;
  end

  // Stage C: partial products of each term, minor split in high and low halves
  ray_t                 c_ray_r;
  logic signed [TW-1:0] c_hi_r [12];
  logic signed [TW-1:0] c_lo_r [12];

  always_ff @(posedge clk) begin
    for (int t = 0; t < 12; t++) begin
      c_hi_r[t] <= TW'(b_x_r[TX[t]]) * TW'($signed(b_m_r[TY[t]][MW-1:LO]));
      c_lo_r[t] <= TW'(b_x_r[TX[t]]) * TW'($signed({1'b0, b_m_r[TY[t]][LO-1:0]}));
    end
    c_ray_r <= b_ray_r;
  end

  // Stage D: recombine partial products
  ray_t                 d_ray_r;
  logic signed [TW-1:0] d_t_r [12];

  always_ff @(posedge clk) begin
    for (int t = 0; t < 12; t++) d_t_r[t] <= (c_hi_r[t] <<< LO) + c_lo_r[t];
    d_ray_r <= c_ray_r;
  end

  // Stage E: determinant and the three numerators
  ray_t                   e_ray_r;
  logic signed [DETW-1:0] e_den_r, e_e1_r, e_e2_r, e_e3_r;

  always_ff @(posedge clk) begin
    e_den_r <= DETW'(d_t_r[0]) + DETW'(d_t_r[1]) + DETW'(d_t_r[2]);
    e_e1_r  <= DETW'(d_t_r[3]) - DETW'(d_t_r[4]) - DETW'(d_t_r[5]);
    e_e2_r  <= DETW'(d_t_r[6]) + DETW'(d_t_r[7]) + DETW'(d_t_r[8]);
    e_e3_r  <= DETW'(d_t_r[9]) - DETW'(d_t_r[10]) + DETW'(d_t_r[11]);
    e_ray_r <= d_ray_r;
  end

  // Stage F: make the determinant positive
  ray_t                   f_ray_r;
  logic signed [DETW-1:0] f_den_r, f_e1_r, f_e2_r, f_e3_r;
  logic                   f_zero_r;

  always_ff @(posedge clk) begin
    if (e_den_r[DETW-1]) begin
      f_den_r <= -e_den_r;
      f_e1_r  <= -e_e1_r;
      f_e2_r  <= -e_e2_r;
      f_e3_r  <= -e_e3_r;
    end else begin
      f_den_r <= e_den_r;
      f_e1_r  <= e_e1_r;
      f_e2_r  <= e_e2_r;
      f_e3_r  <= e_e3_r;
    end
    f_zero_r <= (e_den_r == '0);
    f_ray_r  <= e_ray_r;
  end

  // Stage G: range checks, divider setup and overflow clamp
  tdiv_t         tdiv_r [0:DB];
  logic [WW-1:0] g_num;

  assign g_num = WW'($unsigned(f_e3_r)) << F;

  always_ff @(posedge clk) begin
    tdiv_r[0].ray   <= f_ray_r;
    tdiv_r[0].miss  <= f_zero_r | f_e1_r[DETW-1] | f_e2_r[DETW-1] |
                       (f_e1_r > f_den_r) | (f_e2_r > f_den_r) |
                       f_e3_r[DETW-1] | (f_e3_r == '0);
    tdiv_r[0].clamp <= ((WW'($unsigned(f_den_r)) << DB) <= g_num);
    tdiv_r[0].den   <= $unsigned(f_den_r);
    tdiv_r[0].rem   <= g_num;
    tdiv_r[0].q     <= '0;
  end

  // Distance divider: one quotient bit per stage, MSB first
  for (genvar k = 0; k < DB; k++) begin : g_tdiv
    logic [WW-1:0] dk;
    tdiv_t         tdiv_nxt;
    assign dk = WW'(tdiv_r[k].den) << (DB - 1 - k);
    always_comb begin
      tdiv_nxt = tdiv_r[k];
      if (dk <= tdiv_r[k].rem) begin
        tdiv_nxt.rem       = tdiv_r[k].rem - dk;
        tdiv_nxt.q[DB-1-k] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      tdiv_r[k+1] <= tdiv_nxt;
    end
  end

  // Stage H: hit decision and t * direction
  logic [DB-1:0]         h_tq;
  logic                  h_hit;
  logic                  hh_hit_r;
  logic [DB-1:0]         hh_dist_r;
  logic [2:0][C-1:0]     hh_o_r;
  logic signed [PRW-1:0] hh_prod_r [3];

  assign h_tq  = tdiv_r[DB].clamp ? {DB{1'b1}} : tdiv_r[DB].q;
  assign h_hit = ~tdiv_r[DB].miss & (h_tq > DB'(min_dist_r)) &
                 (h_tq < tdiv_r[DB].ray.nearest);

  always_ff @(posedge clk) begin
    for (int x = 0; x < 3; x++) begin
      hh_prod_r[x] <= PRW'($signed({1'b0, h_tq})) * PRW'($signed(tdiv_r[DB].ray.dv[x]));
    end
    hh_hit_r  <= h_hit;
    hh_dist_r <= h_hit ? h_tq : tdiv_r[DB].ray.nearest;
    hh_o_r    <= tdiv_r[DB].ray.o;
  end

  // Stage I: hit point, floored and saturated
  res_t                 i_res_r;
  logic signed [SW-1:0] i_sum [3];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      i_sum[x] = SW'($signed(hh_o_r[x])) + SW'(hh_prod_r[x] >>> F);
    end
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < 3; x++) begin
      if (i_sum[x] > PT_MAX) i_res_r.pt[x] <= PT_MAX[C-1:0];
      else if (i_sum[x] < PT_MIN) i_res_r.pt[x] <= PT_MIN[C-1:0];
      else i_res_r.pt[x] <= i_sum[x][C-1:0];
    end
    i_res_r.hit   <= hh_hit_r;
    i_res_r.tdist <= hh_dist_r;
  end

  // Stage J: edge products with the point offset and with themselves
  res_t                 j_res_r;
  logic signed [PW-1:0] j_d1_r [3];
  logic signed [PW-1:0] j_d2_r [3];
  logic signed [PW-1:0] j_l1_r [3];
  logic signed [PW-1:0] j_l2_r [3];
  logic signed [DW-1:0] j_rel [3];
  logic signed [DW-1:0] j_e01 [3];
  logic signed [DW-1:0] j_e02 [3];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      j_rel[x] = DW'($signed(i_res_r.pt[x])) - DW'(p0[x]);
      j_e01[x] = DW'(p1[x]) - DW'(p0[x]);
      j_e02[x] = DW'(p2[x]) - DW'(p0[x]);
    end
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < 3; x++) begin
      j_d1_r[x] <= PW'(j_e01[x]) * PW'(j_rel[x]);
      j_d2_r[x] <= PW'(j_e02[x]) * PW'(j_rel[x]);
      j_l1_r[x] <= PW'(j_e01[x]) * PW'(j_e01[x]);
      j_l2_r[x] <= PW'(j_e02[x]) * PW'(j_e02[x]);
    end
    j_res_r <= i_res_r;
  end

  // Stage K: dot products and squared edge lengths
  res_t                   k_res_r;
  logic signed [DOTW-1:0] k_dot1_r, k_dot2_r, k_len1_r, k_len2_r;

  always_ff @(posedge clk) begin
    k_dot1_r <= DOTW'(j_d1_r[0]) + DOTW'(j_d1_r[1]) + DOTW'(j_d1_r[2]);
    k_dot2_r <= DOTW'(j_d2_r[0]) + DOTW'(j_d2_r[1]) + DOTW'(j_d2_r[2]);
    k_len1_r <= DOTW'(j_l1_r[0]) + DOTW'(j_l1_r[1]) + DOTW'(j_l1_r[2]);
    k_len2_r <= DOTW'(j_l2_r[0]) + DOTW'(j_l2_r[1]) + DOTW'(j_l2_r[2]);
    k_res_r  <= j_res_r;
  end

  // Stage L: magnitudes, saturation flags and u/v divider setup
  udiv_t           udiv_r [0:UF];
  logic [DOTW-1:0] l_ad1, l_ad2;

  assign l_ad1 = k_dot1_r[DOTW-1] ? $unsigned(-k_dot1_r) : $unsigned(k_dot1_r);
  assign l_ad2 = k_dot2_r[DOTW-1] ? $unsigned(-k_dot2_r) : $unsigned(k_dot2_r);

  always_ff @(posedge clk) begin
    udiv_r[0].res <= k_res_r;
    udiv_r[0].zu  <= (k_len1_r == '0);
    udiv_r[0].zv  <= (k_len2_r == '0);
    udiv_r[0].su  <= (l_ad1 >= $unsigned(k_len1_r));
    udiv_r[0].sv  <= (l_ad2 >= $unsigned(k_len2_r));
    udiv_r[0].lu  <= $unsigned(k_len1_r);
    udiv_r[0].lv  <= $unsigned(k_len2_r);
    udiv_r[0].ru  <= UW'(l_ad1) << UF;
    udiv_r[0].rv  <= UW'(l_ad2) << UF;
    udiv_r[0].qu  <= '0;
    udiv_r[0].qv  <= '0;
  end

  // u and v dividers side by side, one quotient bit per stage
  for (genvar k = 0; k < UF; k++) begin : g_udiv
    logic [UW-1:0] dku, dkv;
    udiv_t         udiv_nxt;
    assign dku = UW'(udiv_r[k].lu) << (UF - 1 - k);
    assign dkv = UW'(udiv_r[k].lv) << (UF - 1 - k);
    always_comb begin
      udiv_nxt = udiv_r[k];
      if (dku <= udiv_r[k].ru) begin
        udiv_nxt.ru        = udiv_r[k].ru - dku;
        udiv_nxt.qu[UF-1-k] = 1'b1;
      end
      if (dkv <= udiv_r[k].rv) begin
        udiv_nxt.rv        = udiv_r[k].rv - dkv;
        udiv_nxt.qv[UF-1-k] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      udiv_r[k+1] <= udiv_nxt;
    end
  end

  // Output register: zero geometry on a miss
  logic                 o_hit_r;
  logic [DB-1:0]        o_dist_r;
  logic [2:0][C-1:0]    o_pt_r;
  logic [UV_BITS-1:0]   o_u_r, o_v_r;
  udiv_t                fin;

  assign fin = udiv_r[UF];

  always_ff @(posedge clk) begin
    o_hit_r  <= fin.res.hit;
    o_dist_r <= fin.res.tdist;
    if (fin.res.hit) begin
      o_pt_r <= fin.res.pt;
      o_u_r  <= fin.zu ? '0 : (fin.su ? UV_ONE : {1'b0, fin.qu});
      o_v_r  <= fin.zv ? '0 : (fin.sv ? UV_ONE : {1'b0, fin.qv});
    end else begin
      o_pt_r <= '0;
      o_u_r  <= '0;
      o_v_r  <= '0;
    end
  end

  assign out_valid        = vld_r[LAT-1];
  assign out_is_hit       = o_hit_r;
  assign out_hit_distance = o_dist_r;
  assign out_point_x      = $signed(o_pt_r[0]);
  assign out_point_y      = $signed(o_pt_r[1]);
  assign out_point_z      = $signed(o_pt_r[2]);
  assign out_surf_u       = o_u_r;
  assign out_surf_v       = o_v_r;

endmodule

>>> rtl/rph_checker.sv
// Port-level checker for the ray/parallelogram hit test, with its bind.
module rph_sva #(
  parameter int COORD_BITS = rph_pkg::COORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [rph_pkg::DIST_BITS-1:0] in_nearest_so_far,
  input logic                          out_valid,
  input logic                          out_is_hit,
  input logic [rph_pkg::DIST_BITS-1:0] out_hit_distance,
  input logic [COORD_BITS-1:0]         out_point_x,
  input logic [COORD_BITS-1:0]         out_point_y,
  input logic [COORD_BITS-1:0]         out_point_z,
  input logic [rph_pkg::UV_BITS-1:0]   out_surf_u,
  input logic [rph_pkg::UV_BITS-1:0]   out_surf_v
);
  import rph_pkg::*;

  // Every accepted word produces a result on out_valid
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("accepted word did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without a matching accepted word");

  // Hit distance is below the incoming nearest; a miss passes it through
  a_distance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_is_hit && out_hit_distance < $past(in_nearest_so_far, PIPE_LATENCY)) ||
      (!out_is_hit && out_hit_distance == $past(in_nearest_so_far, PIPE_LATENCY)))
    else $error("hit distance inconsistent with incoming nearest");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_hit) |->
      (out_point_x == '0 && out_point_y == '0 && out_point_z == '0 &&
       out_surf_u == '0 && out_surf_v == '0))
    else $error("miss word carries nonzero geometry");

endmodule

bind ray_parallelogram_hit rph_sva #(.COORD_BITS(COORD_BITS)) u_rph_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_nearest_so_far(in_nearest_so_far),
  .out_valid        (out_valid),
  .out_is_hit       (out_is_hit),
  .out_hit_distance (out_hit_distance),
  .out_point_x      (out_point_x),
  .out_point_y      (out_point_y),
  .out_point_z      (out_point_z),
  .out_surf_u       (out_surf_u),
  .out_surf_v       (out_surf_v)
);
